// ===== hw/rtl/hpt_pkg.sv =====
// hpt_pkg: shared types and constants for the homogeneous point transform
// no dependencies; used by hpt_front, hpt_queue, hpt_back and the top level
package hpt_pkg;

   localparam int CoordW  = 32;
   localparam int CoefW   = 16;
   localparam int ProdW   = CoefW + CoordW;
   localparam int SumW    = ProdW + 2;
   localparam int RowW    = 41;           // row sum after floor shift by 8
   localparam int QBits   = 33;           // quotient bits kept below overflow check
   localparam int RemW    = RowW + 1;
   localparam int QDepth  = 4;
   localparam int QPtrW   = $clog2(QDepth);
   localparam int NumRows = 4;

   localparam logic [63:0] RowReset [NumRows] = '{
      64'h0000_0000_0000_0100, 64'h0000_0000_0100_0000,
      64'h0000_0100_0000_0000, 64'h0100_0000_0000_0000};

   typedef enum logic [1:0] {
      REG_ROW_0 = 2'd0,
      REG_ROW_1 = 2'd1,
      REG_ROW_2 = 2'd2,
      REG_ROW_3 = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic signed [CoordW-1:0] point_x;
      logic signed [CoordW-1:0] point_y;
      logic signed [CoordW-1:0] point_z;
   } req_type;

   typedef struct packed {
      logic signed [CoordW-1:0] result_x;
      logic signed [CoordW-1:0] result_y;
      logic signed [CoordW-1:0] result_z;
      logic                     w_was_zero;
      logic                     saturated;
   } rsp_type;

   // one queue entry: truncated row sums of x, y, z and w
   typedef struct packed {
      logic signed [RowW-1:0] v0;
      logic signed [RowW-1:0] v1;
      logic signed [RowW-1:0] v2;
      logic signed [RowW-1:0] w;
   } qent_type;

   function automatic logic signed [CoefW-1:0] coef(input logic [63:0] row,
                                                    input logic [1:0] col);
      coef = signed'(row[16*col +: 16]);
   endfunction

endpackage

// ===== hw/rtl/hpt_front.sv =====
// hpt_front: matrix registers and the two-stage multiply and row sum
// depends on hpt_pkg
module hpt_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [63:0]          csr_wdata,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  hpt_pkg::req_type     req_data,
   input  logic                 q_full,
   output logic                 q_push,
   output hpt_pkg::qent_type    q_wdata
);

   logic [63:0] row_ff [hpt_pkg::NumRows];

   logic signed [hpt_pkg::ProdW-1:0]  prod_ff  [hpt_pkg::NumRows][3];
   logic signed [hpt_pkg::CoordW-1:0] wterm_ff [hpt_pkg::NumRows];
   logic                              f1_valid_ff;
   logic                              f2_valid_ff;
   hpt_pkg::qent_type                 f2_ff;
   logic signed [hpt_pkg::RowW-1:0]   sum_in [hpt_pkg::NumRows];
   logic                              front_en;

   assign front_en  = !(f2_valid_ff && q_full);
   assign req_stall = !front_en;
   assign q_push    = f2_valid_ff && !q_full;
   assign q_wdata   = f2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < hpt_pkg::NumRows; r++) row_ff[r] <= hpt_pkg::RowReset[r];
      end else if (csr_we) begin
         case (hpt_pkg::reg_index_type'(csr_index))
            hpt_pkg::REG_ROW_0: row_ff[0] <= csr_wdata;
            hpt_pkg::REG_ROW_1: row_ff[1] <= csr_wdata;
            hpt_pkg::REG_ROW_2: row_ff[2] <= csr_wdata;
            hpt_pkg::REG_ROW_3: row_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // floor of sum / 256 is an arithmetic shift
   always_comb begin
      logic signed [hpt_pkg::SumW-1:0] acc;
      for (int r = 0; r < hpt_pkg::NumRows; r++) begin
         acc = hpt_pkg::SumW'(prod_ff[r][0]) + hpt_pkg::SumW'(prod_ff[r][1])
             + hpt_pkg::SumW'(prod_ff[r][2]) + hpt_pkg::SumW'(wterm_ff[r]);
         sum_in[r] = hpt_pkg::RowW'(acc >>> 8);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
      end else if (front_en) begin
         f1_valid_ff <= req_valid;
         f2_valid_ff <= f1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (front_en) begin
         for (int r = 0; r < hpt_pkg::NumRows; r++) begin
            prod_ff[r][0] <= hpt_pkg::ProdW'(hpt_pkg::coef(row_ff[r], 2'd0)) *
                             hpt_pkg::ProdW'(req_data.point_x);
            prod_ff[r][1] <= hpt_pkg::ProdW'(hpt_pkg::coef(row_ff[r], 2'd1)) *
                             hpt_pkg::ProdW'(req_data.point_y);
            prod_ff[r][2] <= hpt_pkg::ProdW'(hpt_pkg::coef(row_ff[r], 2'd2)) *
                             hpt_pkg::ProdW'(req_data.point_z);
            // w column sees coordinate 1.0
            wterm_ff[r]   <= {hpt_pkg::coef(row_ff[r], 2'd3), 16'h0000};
         end
         f2_ff.v0 <= sum_in[0];
         f2_ff.v1 <= sum_in[1];
         f2_ff.v2 <= sum_in[2];
         f2_ff.w  <= sum_in[3];
      end
   end

endmodule

// ===== hw/rtl/hpt_queue.sv =====
// hpt_queue: small fifo of row sums between front and back
// depends on hpt_pkg
module hpt_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  hpt_pkg::qent_type    wdata,
   output logic                 full,
   input  logic                 pop,
   output logic                 nonempty,
   output hpt_pkg::qent_type    rdata
);

   hpt_pkg::qent_type             mem_ff [hpt_pkg::QDepth];
   logic [hpt_pkg::QPtrW-1:0]     wptr_ff, rptr_ff;
   logic [hpt_pkg::QPtrW:0]       count_ff;

   assign full     = count_ff == (hpt_pkg::QPtrW+1)'(hpt_pkg::QDepth);
   assign nonempty = count_ff != '0;
   assign rdata    = mem_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (push) wptr_ff <= wptr_ff + 1'b1;
         if (pop)  rptr_ff <= rptr_ff + 1'b1;
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wptr_ff] <= wdata;
   end

endmodule

// ===== hw/rtl/hpt_back.sv =====
// hpt_back: pipelined restoring divide by w, saturation and result register
// depends on hpt_pkg
module hpt_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_nonempty,
   input  hpt_pkg::qent_type    q_rdata,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output hpt_pkg::rsp_type     rsp_data
);

   typedef struct packed {
      logic [hpt_pkg::RemW-1:0]    rem;
      logic [hpt_pkg::QBits-1:0]   nq;      // dividend bits shift out, quotient bits in
      logic                        neg;
      logic                        ovf;
      logic signed [31:0]          pre;     // clipped sum for the zero w case
      logic                        presat;
   } lane_type;

   typedef struct packed {
      logic                        valid;
      logic                        wz;
      logic [hpt_pkg::RowW-1:0]    d;
      lane_type [2:0]              lane;
   } stage_type;

   stage_type        stg_ff [hpt_pkg::QBits+1];
   stage_type        stg0_in;
   logic             rsp_valid_ff;
   hpt_pkg::rsp_type rsp_ff, rsp_in;
   logic             back_en;

   assign back_en   = !(rsp_valid_ff && rsp_stall);
   assign q_pop     = back_en && q_nonempty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   function automatic lane_type prep(input logic signed [hpt_pkg::RowW-1:0] v,
                                     input logic signed [hpt_pkg::RowW-1:0] w,
                                     input logic [hpt_pkg::RowW-1:0] d);
      lane_type l;
      logic [hpt_pkg::RowW-1:0] av;
      av = v[hpt_pkg::RowW-1] ? hpt_pkg::RowW'(-v) : hpt_pkg::RowW'(v);
      l.rem = hpt_pkg::RemW'(av >> 17);
      l.nq  = {av[16:0], 16'h0000};
      l.neg = v[hpt_pkg::RowW-1] ^ w[hpt_pkg::RowW-1];
      // quotient of 2^32 or more always clips
      l.ovf = (av >> 16) >= d;
      if (v > hpt_pkg::RowW'(32'sh7fff_ffff)) begin
         l.pre = 32'sh7fff_ffff;
         l.presat = 1'b1;
      end else if (v < hpt_pkg::RowW'(-33'sh8000_0000)) begin
         l.pre = 32'sh8000_0000;
         l.presat = 1'b1;
      end else begin
         l.pre = 32'(v);
         l.presat = 1'b0;
      end
      return l;
   endfunction

   function automatic stage_type div_step(input stage_type s);
      stage_type o;
      logic [hpt_pkg::RemW-1:0] r2;
      logic                     b;
      o = s;
      for (int i = 0; i < 3; i++) begin
         r2 = {s.lane[i].rem[hpt_pkg::RemW-2:0], s.lane[i].nq[hpt_pkg::QBits-1]};
         b  = r2 >= {1'b0, s.d};
         o.lane[i].rem = b ? r2 - {1'b0, s.d} : r2;
         o.lane[i].nq  = {s.lane[i].nq[hpt_pkg::QBits-2:0], b};
      end
      return o;
   endfunction

   always_comb begin
      logic [hpt_pkg::RowW-1:0] aw;
      aw = q_rdata.w[hpt_pkg::RowW-1] ? hpt_pkg::RowW'(-q_rdata.w)
                                      : hpt_pkg::RowW'(q_rdata.w);
      stg0_in.valid   = q_nonempty;
      stg0_in.wz      = q_rdata.w == '0;
      stg0_in.d       = aw;
      stg0_in.lane[0] = prep(q_rdata.v0, q_rdata.w, aw);
      stg0_in.lane[1] = prep(q_rdata.v1, q_rdata.w, aw);
      stg0_in.lane[2] = prep(q_rdata.v2, q_rdata.w, aw);
   end

   always_comb begin
      stage_type s;
      logic [31:0] r [3];
      logic        sat [3];
      logic [hpt_pkg::QBits-1:0] q;
      s = stg_ff[hpt_pkg::QBits];
      for (int i = 0; i < 3; i++) begin
         q = s.lane[i].nq;
         if (s.wz) begin
            r[i] = s.lane[i].pre;
            sat[i] = s.lane[i].presat;
         end else if (s.lane[i].ovf) begin
            r[i] = s.lane[i].neg ? 32'h8000_0000 : 32'h7fff_ffff;
            sat[i] = 1'b1;
         end else if (s.lane[i].neg) begin
            sat[i] = q > hpt_pkg::QBits'(33'h0_8000_0000);
            r[i] = sat[i] ? 32'h8000_0000 : 32'(-q);
         end else begin
            sat[i] = q > hpt_pkg::QBits'(33'h0_7fff_ffff);
            r[i] = sat[i] ? 32'h7fff_ffff : q[31:0];
         end
      end
      rsp_in.result_x   = r[0];
      rsp_in.result_y   = r[1];
      rsp_in.result_z   = r[2];
      rsp_in.w_was_zero = s.wz;
      rsp_in.saturated  = sat[0] | sat[1] | sat[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= hpt_pkg::QBits; k++) stg_ff[k].valid <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (back_en) begin
         stg_ff[0] <= stg0_in;
         for (int k = 0; k < hpt_pkg::QBits; k++) stg_ff[k+1] <= div_step(stg_ff[k]);
         rsp_valid_ff <= stg_ff[hpt_pkg::QBits].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (back_en) rsp_ff <= rsp_in;
   end

endmodule

// ===== hw/rtl/homogeneous_point_transform_top.sv =====
// homogeneous_point_transform_top: transforms a point by a 4x4 fixed-point matrix
// and divides by w; depends on hpt_pkg, hpt_front, hpt_queue, hpt_back
//
// One point item is taken every cycle while req_stall is low, and one result
// item leaves per item. On its way a point passes the multiply and row sum
// registers in the front, the four-entry queue, an operand stage,
// a 33-stage restoring divider (one quotient bit per stage, three lanes
// side by side) and the result register in the back. Matrix rows are written
// through csr_we/csr_index/csr_wdata and reset to identity; write only while idle.
module homogeneous_point_transform_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [63:0]          csr_wdata,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  hpt_pkg::req_type     req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output hpt_pkg::rsp_type     rsp_data
);

   logic              q_full, q_push, q_pop, q_nonempty;
   hpt_pkg::qent_type q_wdata, q_rdata;

   hpt_front u_front (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata,
      .req_valid, .req_stall, .req_data,
      .q_full, .q_push, .q_wdata
   );

   hpt_queue u_queue (
      .clock, .reset,
      .push(q_push), .wdata(q_wdata), .full(q_full),
      .pop(q_pop), .nonempty(q_nonempty), .rdata(q_rdata)
   );

   hpt_back u_back (
      .clock, .reset, .q_nonempty, .q_rdata, .q_pop,
      .rsp_valid, .rsp_stall, .rsp_data
   );

endmodule
